FILE: src/dtcf_pkg.sv
// Package with shared types, constants and the arctangent table of the tilt filter.
package dtcf_pkg;

	localparam int STEP_W = 5;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_WEIGHT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_A = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_B = 8'd3;

	localparam logic signed [29:0] HALF_PI_Q24 = 30'sd26353589;
	localparam logic signed [29:0] QUARTER_PI_Q24 = 30'sd13176795;
	localparam logic signed [23:0] ANGLE_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] ANGLE_MIN = 24'sh800000;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_LOAD_A,
		OP_LOAD_B,
		OP_ITER,
		OP_SAVE_A,
		OP_SAVE_B,
		OP_RATE,
		OP_LO,
		OP_HI,
		OP_GYRO,
		OP_FUSE1,
		OP_FUSE2,
		OP_FUSE3
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD_A,
		S_ITER_A,
		S_SAVE_A,
		S_LOAD_B,
		S_ITER_B,
		S_SAVE_B,
		S_RATE,
		S_LO,
		S_HI,
		S_GYRO,
		S_FUSE1,
		S_FUSE2,
		S_FUSE3
	} state_t;

	function automatic logic [24:0] atan_entry(input logic [STEP_W-1:0] i);
		logic [24:0] r;
		case (i)
			5'd0: r = 25'd13176795;
			5'd1: r = 25'd7778716;
			5'd2: r = 25'd4110060;
			5'd3: r = 25'd2086331;
			5'd4: r = 25'd1047214;
			5'd5: r = 25'd524117;
			5'd6: r = 25'd262123;
			5'd7: r = 25'd131069;
			default: r = 25'd1 << (5'd24 - i);
		endcase
		return r;
	endfunction

endpackage

FILE: src/dtcf_in_if.sv
// Input channel interface carrying one raw sample set from both sensors.
interface dtcf_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] accel_x_a;
	logic signed [15:0] accel_y_a;
	logic signed [15:0] accel_x_b;
	logic signed [15:0] accel_y_b;
	logic signed [15:0] gyro_z_a;
	logic signed [15:0] gyro_z_b;
	logic [15:0] elapsed_time;

	modport source (output valid, accel_x_a, accel_y_a, accel_x_b, accel_y_b,
		gyro_z_a, gyro_z_b, elapsed_time, input ready);
	modport sink (input valid, accel_x_a, accel_y_a, accel_x_b, accel_y_b,
		gyro_z_a, gyro_z_b, elapsed_time, output ready);
endinterface

FILE: src/dtcf_out_if.sv
// Output channel interface carrying the fused tilt angle.
interface dtcf_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] tilt_angle;

	modport source (output valid, tilt_angle, input ready);
	modport sink (input valid, tilt_angle, output ready);
endinterface

FILE: src/dtcf_ctrl.sv
// Controller state machine that sequences the CORDIC, gyro and fusion steps.
module dtcf_ctrl
	import dtcf_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic out_valid_q, out_valid_d;
	logic last_step;

	assign last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.step = step_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
					state_d = S_LOAD_A;
				end
			end
			S_LOAD_A: begin
				cmd.op = OP_LOAD_A;
				step_d = '0;
				state_d = S_ITER_A;
			end
			S_ITER_A: begin
				cmd.op = OP_ITER;
				step_d = step_q + 1'b1;
				if (last_step) state_d = S_SAVE_A;
			end
			S_SAVE_A: begin
				cmd.op = OP_SAVE_A;
				state_d = S_LOAD_B;
			end
			S_LOAD_B: begin
				cmd.op = OP_LOAD_B;
				step_d = '0;
				state_d = S_ITER_B;
			end
			S_ITER_B: begin
				cmd.op = OP_ITER;
				step_d = step_q + 1'b1;
				if (last_step) state_d = S_SAVE_B;
			end
			S_SAVE_B: begin
				cmd.op = OP_SAVE_B;
				state_d = S_RATE;
			end
			S_RATE: begin
				cmd.op = OP_RATE;
				state_d = S_LO;
			end
			S_LO: begin
				cmd.op = OP_LO;
				state_d = S_HI;
			end
			S_HI: begin
				cmd.op = OP_HI;
				state_d = S_GYRO;
			end
			S_GYRO: begin
				cmd.op = OP_GYRO;
				state_d = S_FUSE1;
			end
			S_FUSE1: begin
				cmd.op = OP_FUSE1;
				state_d = S_FUSE2;
			end
			S_FUSE2: begin
				cmd.op = OP_FUSE2;
				state_d = S_FUSE3;
			end
			S_FUSE3: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = OP_FUSE3;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: src/dtcf_dp.sv
// Datapath with configuration registers, shared CORDIC, gyro multiplier and fusion.
module dtcf_dp
	import dtcf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic signed [15:0] accel_x_a,
	input  logic signed [15:0] accel_y_a,
	input  logic signed [15:0] accel_x_b,
	input  logic signed [15:0] accel_y_b,
	input  logic signed [15:0] gyro_z_a,
	input  logic signed [15:0] gyro_z_b,
	input  logic [15:0] elapsed_time,
	output logic signed [23:0] tilt_angle
);

	logic [16:0] weight_q;
	logic [23:0] scale_q;
	logic signed [15:0] bias_a_q, bias_b_q;

	logic signed [15:0] axa_q, aya_q, axb_q, ayb_q, gza_q, gzb_q;
	logic [15:0] dt_q;

	logic signed [35:0] x_q, y_q;
	logic signed [27:0] z_q;
	logic zero_q;
	logic signed [28:0] zsum_q;
	logic signed [42:0] p_q;
	logic [41:0] lo_q;
	logic signed [33:0] hi_q;
	logic signed [26:0] gyro_q;
	logic signed [20:0] acc_q;
	logic signed [45:0] m1_q;
	logic signed [38:0] m2_q;
	logic signed [23:0] last_q;

	logic signed [15:0] ld_x, ld_y;
	logic signed [16:0] nx, ny;
	logic signed [32:0] x_init, y_init;
	logic signed [35:0] xs, ys;
	logic y_pos;
	logic signed [27:0] ent;
	logic signed [27:0] z_out;
	logic signed [17:0] rate;
	logic signed [59:0] total;
	logic signed [29:0] acc2;
	logic [16:0] w_sat;
	logic signed [27:0] sum1;
	logic signed [46:0] fsum, fsh;

	assign tilt_angle = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= 17'd64225;
			scale_q <= 24'd572222;
			bias_a_q <= '0;
			bias_b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GYRO_WEIGHT: weight_q <= cfg_data[16:0];
				CFG_GYRO_SCALE: scale_q <= cfg_data;
				CFG_GYRO_BIAS_A: bias_a_q <= cfg_data[15:0];
				CFG_GYRO_BIAS_B: bias_b_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ld_x = (cmd.op == OP_LOAD_B) ? axb_q : axa_q;
		ld_y = (cmd.op == OP_LOAD_B) ? ayb_q : aya_q;
		nx = ld_x[15] ? -17'(ld_x) : 17'(ld_x);
		ny = ld_x[15] ? -17'(ld_y) : 17'(ld_y);
		x_init = {nx, 16'h0000};
		y_init = {ny, 16'h0000};
		xs = x_q >>> cmd.step;
		ys = y_q >>> cmd.step;
		y_pos = !y_q[35] && (y_q != '0);
		ent = $signed({3'b000, atan_entry(cmd.step)});
		z_out = zero_q ? '0 : z_q;
		rate = (18'(gza_q) - 18'(bias_a_q)) + (18'(gzb_q) - 18'(bias_b_q));
		total = $signed({hi_q, 26'h0}) + $signed({18'h0, lo_q});
		acc2 = 30'(zsum_q) - HALF_PI_Q24 - (QUARTER_PI_Q24 <<< 1) + 30'sd256;
		w_sat = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
		sum1 = 28'(gyro_q) + 28'(last_q);
		fsum = 47'(m1_q) + 47'(m2_q) + 47'sd32768;
		fsh = fsum >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cmd.op == OP_FUSE3) begin
			if (fsh > 47'(ANGLE_MAX)) last_q <= ANGLE_MAX;
			else if (fsh < 47'(ANGLE_MIN)) last_q <= ANGLE_MIN;
			else last_q <= fsh[23:0];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				axa_q <= accel_x_a;
				aya_q <= accel_y_a;
				axb_q <= accel_x_b;
				ayb_q <= accel_y_b;
				gza_q <= gyro_z_a;
				gzb_q <= gyro_z_b;
				dt_q <= elapsed_time;
			end
			OP_LOAD_A, OP_LOAD_B: begin
				x_q <= 36'(x_init);
				y_q <= 36'(y_init);
				z_q <= '0;
				zero_q <= (ld_x == '0) && (ld_y == '0);
			end
			OP_ITER: begin
				if (y_pos) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + ent;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - ent;
				end
			end
			OP_SAVE_A: zsum_q <= 29'(z_out);
			OP_SAVE_B: zsum_q <= zsum_q + 29'(z_out);
			OP_RATE: p_q <= 43'(rate * $signed({1'b0, scale_q}));
			OP_LO: lo_q <= p_q[25:0] * dt_q;
			OP_HI: hi_q <= 34'($signed(p_q[42:26]) * $signed({1'b0, dt_q}));
			OP_GYRO: begin
				gyro_q <= 27'((total + (60'sd1 <<< 32)) >>> 33);
				acc_q <= 21'(acc2 >>> 9);
			end
			OP_FUSE1: m1_q <= 46'($signed({1'b0, w_sat}) * sum1);
			OP_FUSE2: m2_q <= 39'($signed({1'b0, WEIGHT_ONE - w_sat}) * acc_q);
			default: ;
		endcase
	end

endmodule

FILE: src/dual_imu_tilt_complementary_filter.sv
// Top level of the dual-sensor tilt complementary filter.
// The input channel in_ch takes one sample set from both sensors per transaction:
// accelerometer x and y of each sensor, gyro z of each sensor and the elapsed time.
// The output channel out_ch returns one fused tilt angle per input transaction.
// Configuration is written through cfg_we, cfg_idx and cfg_data; the user must
// do so only while the block is idle, which the block itself does not enforce.
// The shared CORDIC unit is run once for each sensor, and items are handled one at a time.
// A new item is accepted as soon as the previous one has been computed, even while
// its result still waits in the output register.
// If the receiver stalls, the next result waits in the last pipeline step until
// the output register is free, and no further input is accepted meanwhile.
// Reset clears the stored angle to zero, loads the register defaults and drops
// the output valid signal.
module dual_imu_tilt_complementary_filter
	import dtcf_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dtcf_in_if.sink in_ch,
	dtcf_out_if.source out_ch
);

	cmd_t cmd;

	dtcf_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd(cmd)
	);

	dtcf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.accel_x_a(in_ch.accel_x_a),
		.accel_y_a(in_ch.accel_y_a),
		.accel_x_b(in_ch.accel_x_b),
		.accel_y_b(in_ch.accel_y_b),
		.gyro_z_a(in_ch.gyro_z_a),
		.gyro_z_b(in_ch.gyro_z_b),
		.elapsed_time(in_ch.elapsed_time),
		.tilt_angle(out_ch.tilt_angle)
	);

endmodule

FILE: src/dtcf_chk.sv
// Checker of the tilt filter ports, bound to the top level.
module dtcf_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [23:0] tilt_angle
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tilt_angle))
		else $error("Result changed or dropped while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second transaction accepted while one is in work.");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("Result appeared while the block was idle.");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("Result appeared right after acceptance.");

endmodule

bind dual_imu_tilt_complementary_filter dtcf_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.tilt_angle(out_ch.tilt_angle)
);
